// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file ssm_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, off while rst is high.
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ssm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssm_pkg
// Types and constants of the sample set median block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssm_pkg;

  localparam int SAMPLE_W    = 13;
  localparam int COUNT_W     = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] median;
    logic [COUNT_W-1:0]         count;
    logic                       overflow;
  } out_t;

  // One classified transfer on its way from front to back.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       drop;
  } cmd_t;

  typedef enum logic [1:0] {
    B_RUN,
    B_LO,
    B_HI
  } back_state_t;

endpackage

// ===== hw/rtl/ssm_front.sv =====
// ----------------------------------------------------------------------------
// ssm_front
// Takes input transfers and marks the ones that no longer fit in the set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssm_front import ssm_pkg::*; #(
  parameter int MAX_SAMPLES = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  in_t  item,
  input  logic full,
  output logic push,
  output cmd_t cmd
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);

  logic [CW-1:0] fill;
  logic          at_cap;

  assign push   = start && !full;
  assign at_cap = (fill == CW'(MAX_SAMPLES));

  assign cmd.sample = item.sample;
  assign cmd.last   = item.last;
  assign cmd.drop   = at_cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (push) begin
      if (item.last) begin
        fill <= '0;
      end else if (!at_cap) begin
        fill <= fill + CW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/ssm_queue.sv =====
// ----------------------------------------------------------------------------
// ssm_queue
// Short FIFO of classified transfers between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssm_queue import ssm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wr_cmd,
  input  logic pop,
  output logic full,
  output logic valid,
  output cmd_t rd_cmd
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slot [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [LW-1:0] level;
  logic          do_pop;

  assign full   = (level == LW'(QUEUE_DEPTH));
  assign valid  = (level != '0);
  assign rd_cmd = slot[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !do_pop) begin
        level <= level + LW'(1);
      end else if (do_pop && !push) begin
        level <= level - LW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/ssm_back.sv =====
// ----------------------------------------------------------------------------
// ssm_back
// Insertion chain that keeps the set sorted, then picks the middle pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssm_back import ssm_pkg::*; #(
  parameter int MAX_SAMPLES = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic pop,
  output out_t result,
  output logic done
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int IW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  back_state_t                state, state_next;
  logic signed [SAMPLE_W-1:0] chain [MAX_SAMPLES];
  logic signed [SAMPLE_W-1:0] ins_val [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0]     gt;
  logic [CW-1:0]              cnt;
  logic                       ovf;
  logic signed [SAMPLE_W-1:0] lo;
  logic [CW-1:0]              cnt_m1;
  logic [CW-1:0]              lo_sh;
  logic [CW-1:0]              hi_sh;
  logic [IW-1:0]              lo_idx;
  logic [IW-1:0]              hi_idx;
  logic signed [SAMPLE_W:0]   sum;
  logic signed [SAMPLE_W:0]   adj;
  logic                       insert;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_RUN: if (q_valid && q_cmd.last) state_next = B_LO;
      B_LO:  state_next = B_HI;
      B_HI:  state_next = B_RUN;
      default: state_next = B_RUN;
    endcase
  end

  // outputs
  always_comb begin
    pop = 1'b0;
    unique case (state)
      B_RUN:   pop = q_valid;
      B_LO:    pop = 1'b0;
      B_HI:    pop = 1'b0;
      default: pop = 1'b0;
    endcase
  end

  assign insert = pop && !q_cmd.drop;

  // Cells above the insertion point shift up by one; the new sample lands
  // at the first stored cell greater than it, or at the end of the set.
  always_comb begin
    for (int i = 0; i < MAX_SAMPLES; i++) begin
      gt[i] = (CW'(i) < cnt) && (chain[i] > q_cmd.sample);
    end
    for (int i = 0; i < MAX_SAMPLES; i++) begin
      if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
        ins_val[i] = chain[(i > 0) ? i - 1 : 0];
      end else if (gt[i] || CW'(i) == cnt) begin
        ins_val[i] = q_cmd.sample;
      end else begin
        ins_val[i] = chain[i];
      end
    end
  end

  // (n-1)/2 and n/2: the same cell for odd n, the middle pair for even n
  assign cnt_m1 = cnt - CW'(1);
  assign lo_sh  = cnt_m1 >> 1;
  assign hi_sh  = cnt >> 1;
  assign lo_idx = lo_sh[IW-1:0];
  assign hi_idx = hi_sh[IW-1:0];

  // halve with truncation toward zero
  assign sum = $signed({lo[SAMPLE_W-1], lo}) +
               $signed({chain[hi_idx][SAMPLE_W-1], chain[hi_idx]});
  assign adj = sum + $signed({{SAMPLE_W{1'b0}}, sum[SAMPLE_W]});

  always_ff @(posedge clk) begin
    if (insert) begin
      for (int i = 0; i < MAX_SAMPLES; i++) begin
        chain[i] <= ins_val[i];
      end
    end
    if (state == B_LO) begin
      lo <= chain[lo_idx];
    end
    if (state == B_HI) begin
      result.median   <= adj[SAMPLE_W:1];
      result.count    <= COUNT_W'(cnt);
      result.overflow <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_RUN;
      cnt   <= '0;
      ovf   <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == B_HI);
      if (state == B_HI) begin
        cnt <= '0;
        ovf <= 1'b0;
      end else if (pop) begin
        if (q_cmd.drop) begin
          ovf <= 1'b1;
        end else begin
          cnt <= cnt + CW'(1);
        end
      end
    end
  end

endmodule

// ===== hw/rtl/sample_set_median.sv =====
// ----------------------------------------------------------------------------
// sample_set_median
// Median of a set of signed samples closed by a transfer marked last.
//
//   channel   signals                  transfer when
//   input     start, busy, item        start && !busy at rising clk
//   result    done, result             done high, one cycle, no stall
//
// A sample passes through the queue and is inserted into a sorted register
// chain, one per cycle while the back end is in B_RUN. After a transfer
// marked last the back end passes through B_LO, where the lower middle cell
// is latched, and B_HI, where the upper one is added and the halved sum is
// registered together with done. busy rises when the two-entry queue is
// full; the back end pops nothing in B_LO and B_HI.
// rst (synchronous) empties the queue and the set; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sample_set_median import ssm_pkg::*; #(
  parameter int MAX_SAMPLES = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  item,
  output logic done,
  output out_t result
);

  logic push;
  logic pop;
  logic q_valid;
  cmd_t f_cmd;
  cmd_t q_cmd;

  ssm_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .full  (busy),
    .push  (push),
    .cmd   (f_cmd)
  );

  ssm_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (f_cmd),
    .pop    (pop),
    .full   (busy),
    .valid  (q_valid),
    .rd_cmd (q_cmd)
  );

  ssm_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .result  (result),
    .done    (done)
  );

endmodule

// ===== hw/rtl/ssm_checker.sv =====
// ----------------------------------------------------------------------------
// ssm_checker
// Port-level checks of the sample set median block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssm_checker import ssm_pkg::*; #(
  parameter int MAX_SAMPLES = 8
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input out_t result
);

  localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(MAX_SAMPLES);

  logic ovf_res;
  logic full_set;

  assign ovf_res  = done && result.overflow;
  assign full_set = (result.count == FULL_CNT);

  // each result needs several cycles of the back end
  `CHK_ASSERT(a_done_gap, done |=> !done, "two results in consecutive cycles")
  // the queue only fills after a transfer
  `CHK_ASSERT(a_busy_rise, $rose(busy) |-> $past(start), "busy rose without a transfer")
  // an overflowed set always holds a full store
  `CHK_ASSERT(a_ovf_count, ovf_res |-> full_set, "overflow with a partial set")
  `CHK_ASSERT_ALWAYS(a_rst_quiet, rst |=> (!done && !busy), "activity right after reset")

endmodule

bind sample_set_median ssm_checker #(.MAX_SAMPLES(MAX_SAMPLES)) u_ssm_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
